[rtl/core/cht_pkg.sv]
`timescale 1ns / 1ps
package cht_pkg;

  localparam int BUCKETS       = 256;
  localparam int NODES         = 1024;
  localparam int PAYLOAD_WIDTH = 64;

  localparam int KEY_W    = 32;
  localparam int VALUE_W  = 64;
  localparam int CFG_W    = 9;
  localparam int STATUS_W = 3;

  localparam int BKT_AW   = $clog2(BUCKETS);
  localparam int NODE_AW  = $clog2(NODES);
  localparam int PTR_W    = $clog2(NODES + 1);
  localparam int DIV_W    = $clog2(BUCKETS + 1);
  localparam int CNT_W    = $clog2(KEY_W + 1);
  localparam int NODE_W   = KEY_W + PAYLOAD_WIDTH + PTR_W;

  localparam logic [CFG_W-1:0] BUCKET_CNT_RST = CFG_W'(256);

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_POOL_FULL = 3'd4
  } status_t;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_SEARCH = 1'b1
  } action_t;

endpackage

[rtl/core/cht_ram.sv]
`timescale 1ns / 1ps
module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/cht_mod.sv]
`timescale 1ns / 1ps
// Restoring remainder unit: one dividend bit per cycle.
module cht_mod (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [cht_pkg::KEY_W-1:0]   dividend,
  input  logic [cht_pkg::DIV_W-1:0]   divisor,
  output logic                        done,
  output logic [cht_pkg::DIV_W-1:0]   remainder
);
  import cht_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [KEY_W-1:0] dvd_r;
  logic [DIV_W-1:0] div_r;
  logic [DIV_W-1:0] rem_r;

  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic [DIV_W-1:0] rem_step;

  // Shift in the next dividend bit, subtract when the divisor fits.
  always_comb begin
    trial    = {rem_r, dvd_r[KEY_W-1]};
    diff     = trial - {1'b0, div_r};
    rem_step = (trial >= {1'b0, div_r}) ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(KEY_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      div_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[KEY_W-2:0], 1'b0};
      rem_r <= rem_step;
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

[rtl/core/chained_hash_table_int_key.sv]
`timescale 1ns / 1ps
// Hash table with separate chaining over a fixed pool of 1024 nodes and 256 buckets.
// Each input transaction inserts/updates a signed 32-bit key with a 64-bit payload
// (action 0) or searches for a key (action 1); exactly one result transaction follows
// with a status code (inserted, updated, found, not found, pool full) and, for a hit
// on search, the stored payload. The bucket is |key| mod bucket_count, where a count
// of 0 acts as 1 and counts above 256 act as 256; changing the count strands keys
// hashed under the old one. Items are handled one at a time: an item first runs the
// bit-serial remainder unit to find its bucket, then walks the chain, and the walk
// ends on a match or when the chain runs out. Each node visit costs one read of the
// single-ported-read node memory plus the compare. The bucket heads come out of
// reset empty at once (per-bucket valid flops), so there is no clearing pass.
// When the pool is full an insert of a new key is dropped and answers pool full;
// updates of existing keys still succeed. The result register lets the next item
// be accepted while a finished result still waits on out_tready.
module chained_hash_table_int_key (
  input  logic                        clk,
  input  logic                        rst_n,
  // config write: bucket_count
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [cht_pkg::CFG_W-1:0]   cfg_data,
  // input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [95:0]                 in_tdata,   // [31:0] key, [95:32] value
  input  logic [0:0]                  in_tuser,   // [0] action
  // result stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [63:0]                 out_tdata,  // [63:0] found_value
  output logic [2:0]                  out_tuser   // [2:0] status
);
  import cht_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_HEAD,
    S_WALK,
    S_NODE,
    S_RESULT
  } state_t;

  state_t                    state_r;
  logic [CFG_W-1:0]          bucket_cnt_r;
  logic [BUCKETS-1:0]        head_vld_r;
  logic [PTR_W-1:0]          nodes_used_r;
  logic [PTR_W-1:0]          cur_r;
  logic [PTR_W-1:0]          steps_r;
  logic [PTR_W-1:0]          head_r;
  logic                      act_r;
  logic [KEY_W-1:0]          key_r;
  logic [PAYLOAD_WIDTH-1:0]  pay_r;
  status_t                   status_r;
  logic [VALUE_W-1:0]        found_r;
  logic                      out_vld_r;
  status_t                   out_status_r;
  logic [VALUE_W-1:0]        out_value_r;

  logic                      in_acc;
  logic signed [KEY_W-1:0]   in_key;
  logic [KEY_W-1:0]          key_mag;
  logic [DIV_W-1:0]          divisor;
  logic                      mod_done;
  logic [DIV_W-1:0]          mod_rem;
  logic [BKT_AW-1:0]         bkt_idx;

  logic                      bkt_we;
  logic [PTR_W-1:0]          bkt_rdata;
  logic [PTR_W-1:0]          head_ptr;

  logic                      node_we;
  logic [NODE_AW-1:0]        node_waddr;
  logic [NODE_W-1:0]         node_wdata;
  logic [NODE_W-1:0]         node_rdata;
  logic [KEY_W-1:0]          rd_key;
  logic [PAYLOAD_WIDTH-1:0]  rd_pay;
  logic [PTR_W-1:0]          rd_link;

  logic                      walk_more;
  logic                      key_hit;
  logic                      resolve;
  logic                      push_new;
  status_t                   status_nxt;
  logic [VALUE_W-1:0]        found_nxt;
  logic                      out_free;

  // Take a new item only when no item is in flight; a parked result does not block.
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // |key| as an unsigned 32-bit magnitude; the most negative key maps to 2^31.
  assign in_key  = in_tdata[KEY_W-1:0];
  assign key_mag = in_key[KEY_W-1] ? (KEY_W'(0) - in_tdata[KEY_W-1:0])
                                   : in_tdata[KEY_W-1:0];

  // Clamp the divisor into 1..BUCKETS.
  always_comb begin
    if (bucket_cnt_r == '0) begin
      divisor = DIV_W'(1);
    end else if (bucket_cnt_r > CFG_W'(BUCKETS)) begin
      divisor = DIV_W'(BUCKETS);
    end else begin
      divisor = DIV_W'(bucket_cnt_r);
    end
  end

  cht_mod u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_acc),
    .dividend  (key_mag),
    .divisor   (divisor),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // Remainder holds until the next item starts, so it drives the bucket address.
  assign bkt_idx = mod_rem[BKT_AW-1:0];

  cht_ram #(
    .WIDTH (PTR_W),
    .DEPTH (BUCKETS)
  ) u_bucket_ram (
    .clk   (clk),
    .we    (bkt_we),
    .waddr (bkt_idx),
    .wdata (nodes_used_r),
    .raddr (bkt_idx),
    .rdata (bkt_rdata)
  );

  // An untouched bucket reads as the empty marker.
  assign head_ptr = head_vld_r[bkt_idx] ? bkt_rdata : PTR_W'(NODES);

  cht_ram #(
    .WIDTH (NODE_W),
    .DEPTH (NODES)
  ) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (cur_r[NODE_AW-1:0]),
    .rdata (node_rdata)
  );

  // Node word: link in the top, payload in the middle, key in the bottom.
  assign rd_key  = node_rdata[KEY_W-1:0];
  assign rd_pay  = node_rdata[KEY_W +: PAYLOAD_WIDTH];
  assign rd_link = node_rdata[NODE_W-1 -: PTR_W];

  assign walk_more = (cur_r < PTR_W'(NODES)) && (steps_r < nodes_used_r);
  assign key_hit   = (state_r == S_NODE) && (rd_key == key_r);

  // Settle the item either on a key match or when the walk runs out of chain.
  always_comb begin
    resolve    = 1'b0;
    push_new   = 1'b0;
    node_we    = 1'b0;
    bkt_we     = 1'b0;
    node_waddr = cur_r[NODE_AW-1:0];
    node_wdata = {rd_link, pay_r, key_r};
    status_nxt = ST_NOT_FOUND;
    found_nxt  = '0;
    if (key_hit) begin
      resolve = 1'b1;
      if (act_r == ACT_SEARCH) begin
        status_nxt = ST_FOUND;
        found_nxt  = VALUE_W'(rd_pay);
      end else begin
        // Rewrite the whole node, keeping the link just read.
        node_we    = 1'b1;
        status_nxt = ST_UPDATED;
      end
    end else if ((state_r == S_WALK) && !walk_more) begin
      resolve = 1'b1;
      if (act_r == ACT_SEARCH) begin
        status_nxt = ST_NOT_FOUND;
      end else if (nodes_used_r >= PTR_W'(NODES)) begin
        status_nxt = ST_POOL_FULL;
      end else begin
        // Push the next free node at the chain head.
        push_new   = 1'b1;
        node_we    = 1'b1;
        bkt_we     = 1'b1;
        node_waddr = nodes_used_r[NODE_AW-1:0];
        node_wdata = {head_r, pay_r, key_r};
        status_nxt = ST_INSERTED;
      end
    end
  end

  assign out_free = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      bucket_cnt_r <= BUCKET_CNT_RST;
      head_vld_r   <= '0;
      nodes_used_r <= '0;
      out_vld_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        bucket_cnt_r <= cfg_data;
      end
      // Load a fresh result, or drop the one just taken.
      if ((state_r == S_RESULT) && out_free) begin
        out_vld_r <= 1'b1;
      end else if (out_vld_r && out_tready) begin
        out_vld_r <= 1'b0;
      end
      if (push_new) begin
        head_vld_r[bkt_idx] <= 1'b1;
        nodes_used_r        <= nodes_used_r + PTR_W'(1);
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_HASH;
          end
        end
        S_HASH: begin
          if (mod_done) begin
            state_r <= S_HEAD;
          end
        end
        S_HEAD: begin
          state_r <= S_WALK;
        end
        S_WALK: begin
          if (resolve) begin
            state_r <= S_RESULT;
          end else begin
            state_r <= S_NODE;
          end
        end
        S_NODE: begin
          if (resolve) begin
            state_r <= S_RESULT;
          end else begin
            state_r <= S_WALK;
          end
        end
        S_RESULT: begin
          // Hold until the result register frees up.
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers: no reset needed.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r <= in_tuser[0];
      key_r <= in_tdata[KEY_W-1:0];
      pay_r <= in_tdata[KEY_W +: PAYLOAD_WIDTH];
    end
    if (state_r == S_HEAD) begin
      cur_r   <= head_ptr;
      head_r  <= head_ptr;
      steps_r <= '0;
    end else if ((state_r == S_NODE) && !resolve) begin
      cur_r   <= rd_link;
      steps_r <= steps_r + PTR_W'(1);
    end
    if (resolve) begin
      status_r <= status_nxt;
      found_r  <= found_nxt;
    end
    if ((state_r == S_RESULT) && out_free) begin
      out_status_r <= status_r;
      out_value_r  <= found_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;

  // Pool fill never passes the pool size.
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nodes_used_r <= PTR_W'(NODES))
    else $error("node pool count overran");

  // A push advances the fill count by exactly one.
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    push_new |=> nodes_used_r == $past(nodes_used_r) + PTR_W'(1))
    else $error("fill count did not advance on push");

  // The walk never visits more nodes than exist.
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_NODE) |-> steps_r < nodes_used_r)
    else $error("chain walk exceeded node count");

  // A result is loaded only when the output register is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESULT && out_vld_r && !out_tready) |=> state_r == S_RESULT)
    else $error("result register overwritten");

endmodule
